// ===== src/b64d_pkg.sv =====
package b64d_pkg;

  // Number of decoded groups that can wait between the front and back parts.
  localparam int unsigned FIFO_DEPTH = 4;

  // Up to three results caused by one character, oldest in data[0].
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      cnt;
    logic            byte_valid;
    logic            last;
  } b64d_rec_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } b64d_sym_t;

  // Maps a character of the standard alphabet to its 6-bit symbol.
  function automatic b64d_sym_t b64d_classify(input logic [7:0] c);
    b64d_sym_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    priority if (c >= 8'h41 && c <= 8'h5A) begin
      s.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.value = 6'd62;
    end else if (c == 8'h2F) begin
      s.value = 6'd63;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== src/b64d_front.sv =====
module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_code_i,
  input  logic       end_of_message_i,
  output logic       rec_push_o,
  output b64d_rec_t  rec_o
);

  logic [1:0]      held_q, held_d;
  logic [2:0][5:0] store_q;
  logic [2:0][5:0] eff;
  b64d_sym_t       sym;
  logic            full_group;
  logic [1:0]      held_after;
  logic [7:0]      g0, g1, tail;
  b64d_rec_t       rec;

  always_comb begin
    sym = b64d_classify(char_code_i);
    for (int i = 0; i < 3; i++) begin
      eff[i] = (sym.valid && held_q == 2'(i)) ? sym.value : store_q[i];
    end
    full_group = sym.valid && (held_q == 2'd3);
    if (full_group) begin
      held_after = 2'd0;
    end else if (sym.valid) begin
      held_after = held_q + 2'd1;
    end else begin
      held_after = held_q;
    end
    g0   = {eff[0], eff[1][5:4]};
    g1   = {eff[1][3:0], eff[2][5:2]};
    tail = 8'd0;

    rec.data       = '0;
    rec.cnt        = 2'd0;
    rec.byte_valid = 1'b1;
    rec.last       = end_of_message_i;
    if (full_group) begin
      rec.data = {{eff[2][1:0], sym.value}, g1, g0};
      rec.cnt  = 2'd3;
    end else if (end_of_message_i) begin
      unique case (held_after)
        2'd0: begin
          rec.cnt = 2'd0;
        end
        2'd1: begin
          tail        = {eff[0], 2'b00};
          rec.data[0] = tail;
          rec.cnt     = (tail != 8'd0) ? 2'd1 : 2'd0;
        end
        2'd2: begin
          tail        = {eff[1][3:0], 4'b0000};
          rec.data[0] = g0;
          rec.data[1] = tail;
          rec.cnt     = (tail != 8'd0) ? 2'd2 : 2'd1;
        end
        2'd3: begin
          tail        = {eff[2][1:0], 6'b000000};
          rec.data[0] = g0;
          rec.data[1] = g1;
          rec.data[2] = tail;
          rec.cnt     = (tail != 8'd0) ? 2'd3 : 2'd2;
        end
        default: begin
          rec.cnt = 2'd0;
        end
      endcase
      // A message end with nothing left to flush still sends a bare end marker.
      if (rec.cnt == 2'd0) begin
        rec.data       = '0;
        rec.cnt        = 2'd1;
        rec.byte_valid = 1'b0;
      end
    end
  end

  always_comb begin
    held_d = held_q;
    if (accept_i) begin
      held_d = end_of_message_i ? 2'd0 : held_after;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 2'd0;
    end else begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && sym.valid && !full_group) begin
      store_q[held_q] <= sym.value;
    end
  end

  assign rec_push_o = accept_i && (rec.cnt != 2'd0);
  assign rec_o      = rec;

endmodule

// ===== src/b64d_fifo.sv =====
module b64d_fifo
  import b64d_pkg::*;
#(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  b64d_rec_t wdata_i,
  input  logic      pop_i,
  output b64d_rec_t rdata_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64d_rec_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== src/b64d_back.sv =====
module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  b64d_rec_t  q_rec_i,
  output logic       q_pop_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       last_of_message_o
);

  logic       cur_valid_q, cur_valid_d;
  b64d_rec_t  cur_q, cur_d;
  logic [1:0] idx_q, idx_d;
  logic       at_end, done;

  assign at_end = (idx_q == cur_q.cnt - 2'd1);
  assign done   = !cur_valid_q || (pop && at_end);
  assign q_pop_o = done && !q_empty_i;

  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    if (done) begin
      cur_valid_d = !q_empty_i;
      cur_d       = q_rec_i;
      idx_d       = 2'd0;
    end else if (pop) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  assign empty             = !cur_valid_q;
  assign data_byte_o       = (idx_q == 2'd3) ? 8'd0 : cur_q.data[idx_q];
  assign byte_valid_o      = cur_q.byte_valid;
  assign last_of_message_o = cur_q.last && at_end;

endmodule

// ===== src/base64_decoder_lenient_core.sv =====
// Path: a result goes into the group queue, then is loaded into the output stage.
// Throughput: one character per cycle unless full and one result popped per cycle
// unless empty; a character may cause up to three results via a small group queue.
// Reset: asynchronous, active low; clears the symbol count, queue and output stage.
module base64_decoder_lenient_core
  import b64d_pkg::*;
#(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code_i,
  input  logic       end_of_message_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       last_of_message_o
);

  logic      accept;
  logic      rec_push;
  b64d_rec_t rec_w, rec_r;
  logic      q_pop, q_empty;

  assign accept = push && !full;

  b64d_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .char_code_i     (char_code_i),
    .end_of_message_i(end_of_message_i),
    .rec_push_o      (rec_push),
    .rec_o           (rec_w)
  );

  b64d_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rec_push),
    .wdata_i(rec_w),
    .pop_i  (q_pop),
    .rdata_o(rec_r),
    .full_o (full),
    .empty_o(q_empty)
  );

  b64d_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_rec_i          (rec_r),
    .q_pop_o          (q_pop),
    .empty            (empty),
    .pop              (pop),
    .data_byte_o      (data_byte_o),
    .byte_valid_o     (byte_valid_o),
    .last_of_message_o(last_of_message_o)
  );

endmodule

// ===== tb/b64d_checker.sv =====
module b64d_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_message_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  data_byte_o,
  input  logic        byte_valid_o,
  input  logic        last_of_message_o,
  output int unsigned errors,
  output int unsigned pending,
  output int unsigned results_checked
);

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } dec_result_t;

  dec_result_t expected_bytes[$];
  logic [1:0]  group_fill;
  logic [5:0]  group_sextets [3];

  initial begin
    errors = 0;
    pending = 0;
    results_checked = 0;
    group_fill = 2'd0;
  end

  function automatic logic sextet_of(input logic [7:0] c, output logic [5:0] v);
    v = 6'd0;
    if (c >= "A" && c <= "Z") begin
      v = 6'(c - "A");
      return 1'b1;
    end
    if (c >= "a" && c <= "z") begin
      v = 6'(c - "a" + 8'd26);
      return 1'b1;
    end
    if (c >= "0" && c <= "9") begin
      v = 6'(c - "0" + 8'd52);
      return 1'b1;
    end
    if (c == "+") begin
      v = 6'd62;
      return 1'b1;
    end
    if (c == "/") begin
      v = 6'd63;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  // Predicts the decoded bytes caused by one accepted character.
  task automatic decode_char(input logic [7:0] c, input logic eom);
    logic [5:0]  v;
    logic [5:0]  s0;
    logic [5:0]  s1;
    logic [5:0]  s2;
    logic [7:0]  tail;
    dec_result_t batch[$];
    s0 = group_sextets[0];
    s1 = group_sextets[1];
    s2 = group_sextets[2];
    if (sextet_of(c, v)) begin
      if (group_fill == 2'd3) begin
        batch.push_back('{{s0, s1[5:4]}, 1'b1, 1'b0});
        batch.push_back('{{s1[3:0], s2[5:2]}, 1'b1, 1'b0});
        batch.push_back('{{s2[1:0], v}, 1'b1, 1'b0});
        group_fill = 2'd0;
      end else begin
        group_sextets[group_fill] = v;
        group_fill = group_fill + 2'd1;
      end
    end
    if (eom) begin
      s0 = group_sextets[0];
      s1 = group_sextets[1];
      s2 = group_sextets[2];
      case (group_fill)
        2'd1: begin
          tail = {s0, 2'b00};
          if (tail != 8'd0) batch.push_back('{tail, 1'b1, 1'b0});
        end
        2'd2: begin
          batch.push_back('{{s0, s1[5:4]}, 1'b1, 1'b0});
          tail = {s1[3:0], 4'b0000};
          if (tail != 8'd0) batch.push_back('{tail, 1'b1, 1'b0});
        end
        2'd3: begin
          batch.push_back('{{s0, s1[5:4]}, 1'b1, 1'b0});
          batch.push_back('{{s1[3:0], s2[5:2]}, 1'b1, 1'b0});
          tail = {s2[1:0], 6'b000000};
          if (tail != 8'd0) batch.push_back('{tail, 1'b1, 1'b0});
        end
        default: begin
        end
      endcase
      group_fill = 2'd0;
      if (batch.size() == 0) batch.push_back('{8'd0, 1'b0, 1'b0});
      batch[batch.size() - 1].last = 1'b1;
    end
    foreach (batch[i]) expected_bytes.push_back(batch[i]);
  endtask

  task automatic check_result();
    dec_result_t exp;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected result data=%02h valid=%b last=%b",
                                data_byte_o, byte_valid_o, last_of_message_o));
      return;
    end
    exp = expected_bytes.pop_front();
    results_checked++;
    if (byte_valid_o !== exp.valid)
      report_mismatch($sformatf("byte_valid got %b expected %b", byte_valid_o, exp.valid));
    if (last_of_message_o !== exp.last)
      report_mismatch($sformatf("last_of_message got %b expected %b",
                                last_of_message_o, exp.last));
    if (exp.valid && data_byte_o !== exp.data)
      report_mismatch($sformatf("data_byte got %02h expected %02h", data_byte_o, exp.data));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_fill = 2'd0;
      expected_bytes.delete();
    end else begin
      if (push && !full) decode_char(char_code_i, end_of_message_i);
      if (pop && !empty) check_result();
    end
    pending = expected_bytes.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;

  localparam int unsigned ItemTarget = 410;
  localparam int unsigned CycleLimit = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  char_code_i;
  logic        end_of_message_i;
  logic        empty;
  logic        pop;
  logic [7:0]  data_byte_o;
  logic        byte_valid_o;
  logic        last_of_message_o;

  int unsigned errors;
  int unsigned pending;
  int unsigned results_checked;
  int unsigned chars_sent;
  int unsigned messages_sent;
  int unsigned cycle_count;
  bit          in_steady;
  bit          out_steady;
  string       b64_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  base64_decoder_lenient_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .char_code_i      (char_code_i),
    .end_of_message_i (end_of_message_i),
    .empty            (empty),
    .pop              (pop),
    .data_byte_o      (data_byte_o),
    .byte_valid_o     (byte_valid_o),
    .last_of_message_o(last_of_message_o)
  );

  b64d_checker chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .char_code_i      (char_code_i),
    .end_of_message_i (end_of_message_i),
    .empty            (empty),
    .pop              (pop),
    .data_byte_o      (data_byte_o),
    .byte_valid_o     (byte_valid_o),
    .last_of_message_o(last_of_message_o),
    .errors           (errors),
    .pending          (pending),
    .results_checked  (results_checked)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eom);
    int unsigned gap;
    push <= 1'b1;
    char_code_i <= c;
    end_of_message_i <= eom;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    chars_sent++;
    if (eom) messages_sent++;
    gap = in_steady ? 0 : idle_len();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s, input logic eom);
    for (int i = 0; i < s.len(); i++) send_char(s[i], eom && (i == s.len() - 1));
  endtask

  initial begin
    int unsigned msg_len;
    logic [7:0]  c;
    cycle_count = 0;
    chars_sent = 0;
    messages_sent = 0;
    in_steady = 1'b0;
    out_steady = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    char_code_i = 8'd0;
    end_of_message_i = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty message, then a full group closed by its own fourth character.
    send_text("=", 1'b1);
    send_text("TWFu", 1'b1);
    // Partial groups of one, two and three symbols; nonzero and zero tails for one and three, zero tails for two.
    send_text("Q", 1'b1);
    send_text("A", 1'b1);
    send_text("QQ", 1'b1);
    send_text("QA", 1'b1);
    send_text("QUB", 1'b1);
    send_text("QUE", 1'b1);
    // All-ones symbols framed by skipped extreme codes.
    send_char(8'h00, 1'b0);
    send_text("////", 1'b0);
    send_char(8'hFF, 1'b1);

    while (chars_sent < ItemTarget) begin
      if ($urandom_range(0, 4) == 0) in_steady = !in_steady;
      if ($urandom_range(0, 4) == 0) out_steady = !out_steady;
      msg_len = ($urandom_range(0, 99) < 10) ? $urandom_range(10, 30) : $urandom_range(1, 9);
      for (int i = 0; i < msg_len; i++) begin
        if ($urandom_range(0, 99) < 85) c = b64_alphabet[$urandom_range(0, 63)];
        else if ($urandom_range(0, 3) == 0) c = "=";
        else c = 8'($urandom_range(0, 255));
        send_char(c, i == msg_len - 1);
      end
    end
    push <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d characters in %0d messages, with %0d decoded results checked.",
             chars_sent, messages_sent, results_checked);
    $display("Mismatches reported: %0d.", errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      pop <= 1'b1;
      @(posedge clk_i);
      if (!empty) begin
        gap = out_steady ? 0 : idle_len();
        if (gap != 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

endmodule

// ===== filelist.f =====
src/b64d_pkg.sv
src/b64d_front.sv
src/b64d_fifo.sv
src/b64d_back.sv
src/base64_decoder_lenient_core.sv
tb/b64d_checker.sv
tb/tb.sv
